>>> rtl/mipmap_box_downsample_core_assert.svh
// Assertion macros for the mipmap box downsampler.
// Included by the top level; relies on no other file.
`ifndef MIPMAP_BOX_DOWNSAMPLE_CORE_ASSERT_SVH
`define MIPMAP_BOX_DOWNSAMPLE_CORE_ASSERT_SVH

// The condition must never hold outside reset.
`define MBD_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// The antecedent in one cycle implies the consequent in the same cycle.
`define MBD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/mbd_pkg.sv
// Shared types and constants of the mipmap box downsampler.
// Used by every RTL module; depends on nothing else.
`default_nettype none

package mbd_pkg;

  // Field widths fixed by the interface.
  localparam int COLOR_W = 8;
  localparam int CFG_W   = 11;
  localparam int LEVEL_W = 3;

  // Parameter defaults.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_LEVEL  = 7;

  // Register reset values.
  localparam logic [CFG_W-1:0]   RST_BASE_WIDTH  = CFG_W'(1024);
  localparam logic [CFG_W-1:0]   RST_BASE_HEIGHT = CFG_W'(1024);
  localparam logic [LEVEL_W-1:0] RST_LEVEL       = LEVEL_W'(1);

  // Configuration port: byte address width and register word indexes.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_BASE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_BASE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LEVEL       = 2'd2;

  // Classified pixel handed from the front end to the back end.
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               acc;   // add the stored partial sum
    logic               wr;    // write the new partial sum back
    logic               emit;  // block complete, produce a texel
    logic               last;  // final texel of the mip image
    logic [LEVEL_W-1:0] lv;    // effective mip level
  } cmd_t;

  // One finished texel.
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/mbd_fifo.sv
// Two-entry queue used between the front and back ends and on the result side.
// Depends on mbd_pkg for its default width.
`default_nettype none

module mbd_fifo #(
  parameter int WIDTH = $bits(mbd_pkg::res_t)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import mbd_pkg::*;

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push_ok;
  logic             pop_ok;

  // Status and head of queue.
  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = slot[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= !rd_ptr;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 2'd1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mbd_front.sv
// Front end: tracks the raster position and classifies each accepted pixel.
// Depends on mbd_pkg.
`default_nettype none

module mbd_front #(
  parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_LEVEL  = mbd_pkg::DEF_MAX_LEVEL,
  parameter int IDX_W      = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [mbd_pkg::COLOR_W-1:0]  red,
  input  logic [mbd_pkg::COLOR_W-1:0]  green,
  input  logic [mbd_pkg::COLOR_W-1:0]  blue,
  input  logic [mbd_pkg::CFG_W-1:0]    base_width,
  input  logic [mbd_pkg::CFG_W-1:0]    base_height,
  input  logic [mbd_pkg::LEVEL_W-1:0]  level,
  input  logic                         cfg_wr,
  output mbd_pkg::cmd_t                cmd,
  output logic [IDX_W-1:0]             idx
);
  import mbd_pkg::*;

  localparam int POS_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 1);

  logic [POS_W-1:0]   col_pos;
  logic [POS_W-1:0]   col_pos_next;
  logic [ROW_W-1:0]   row_pos;
  logic [ROW_W-1:0]   row_pos_next;
  logic [WD_W-1:0]    w;
  logic [HT_W-1:0]    h;
  logic [LEVEL_W-1:0] lv;
  logic [WD_W-1:0]    out_w;
  logic [HT_W-1:0]    out_h;
  logic [POS_W-1:0]   tx;
  logic [ROW_W-1:0]   ty;
  logic [POS_W-1:0]   xmask;
  logic [ROW_W-1:0]   ymask;
  logic               in_range;
  logic               blk_first;
  logic               blk_last;

  // Clamp the image size and level to what the block supports.
  always_comb begin
    if (base_width == '0) begin
      w = WD_W'(1);
    end else if (32'(base_width) > 32'(MAX_WIDTH)) begin
      w = WD_W'(MAX_WIDTH);
    end else begin
      w = WD_W'(base_width);
    end
    if (base_height == '0) begin
      h = HT_W'(1);
    end else if (32'(base_height) > 32'(MAX_HEIGHT)) begin
      h = HT_W'(MAX_HEIGHT);
    end else begin
      h = HT_W'(base_height);
    end
    if (32'(level) > 32'(MAX_LEVEL)) begin
      lv = LEVEL_W'(MAX_LEVEL);
    end else begin
      lv = level;
    end
  end

  // Block geometry of the current pixel.
  always_comb begin
    for (int i = 0; i < POS_W; i++) begin
      xmask[i] = (i < int'(lv));
    end
    for (int i = 0; i < ROW_W; i++) begin
      ymask[i] = (i < int'(lv));
    end
    out_w     = w >> lv;
    out_h     = h >> lv;
    tx        = col_pos >> lv;
    ty        = row_pos >> lv;
    in_range  = (32'(tx) < 32'(out_w)) && (32'(ty) < 32'(out_h));
    blk_first = ((col_pos & xmask) == '0) && ((row_pos & ymask) == '0);
    blk_last  = ((col_pos & xmask) == xmask) && ((row_pos & ymask) == ymask);
  end

  // Classification handed to the back end.
  always_comb begin
    cmd.red   = red;
    cmd.green = green;
    cmd.blue  = blue;
    cmd.wr    = in_range && (lv != '0);
    cmd.acc   = in_range && (lv != '0) && !blk_first;
    cmd.emit  = in_range && blk_last;
    cmd.last  = (32'(tx) + 32'd1 == 32'(out_w)) && (32'(ty) + 32'd1 == 32'(out_h));
    cmd.lv    = lv;
    idx       = in_range ? IDX_W'(tx) : '0;
  end

  // Raster position of the next pixel.
  always_comb begin
    col_pos_next = col_pos;
    row_pos_next = row_pos;
    if (cfg_wr) begin
      col_pos_next = '0;
      row_pos_next = '0;
    end else if (accept) begin
      if (32'(col_pos) + 32'd1 >= 32'(w)) begin
        col_pos_next = '0;
        if (32'(row_pos) + 32'd1 >= 32'(h)) begin
          row_pos_next = '0;
        end else begin
          row_pos_next = row_pos + ROW_W'(1);
        end
      end else begin
        col_pos_next = col_pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mbd_back.sv
// Back end: line store read-modify-write of block sums and texel averaging.
// Depends on mbd_pkg.
`default_nettype none

module mbd_back #(
  parameter int MAX_WIDTH = mbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LEVEL = mbd_pkg::DEF_MAX_LEVEL,
  parameter int IDX_W     = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mbd_pkg::cmd_t      in_cmd,
  input  logic [IDX_W-1:0]   in_idx,
  output logic               res_valid,
  input  logic               res_ready,
  output mbd_pkg::res_t      res
);
  import mbd_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int TOP_LEVEL  = (2 ** LEVEL_W) - 1;
  localparam int EFF_LEVEL  = (MAX_LEVEL > TOP_LEVEL) ? TOP_LEVEL : MAX_LEVEL;
  localparam int SUM_W      = COLOR_W + 2 * EFF_LEVEL;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  sums_t            line_mem [LINE_DEPTH];
  sums_t            rdata;
  sums_t            byp_sum;
  logic             byp_hit;
  sums_t            base;
  sums_t            sum;
  logic             b_valid;
  cmd_t             b_cmd;
  logic [IDX_W-1:0] b_idx;
  logic             b_done;
  logic             take;
  logic             wr_en;
  logic [3:0]       shamt;

  // Stage handshake: the held item leaves unless its texel cannot be queued.
  assign b_done    = b_valid && (!b_cmd.emit || res_ready);
  assign in_ready  = !b_valid || b_done;
  assign take      = in_valid && in_ready;
  assign wr_en     = b_done && b_cmd.wr;
  assign res_valid = b_valid && b_cmd.emit;

  // Line store: read on entry to the stage, write when the stage retires.
  always_ff @(posedge clk) begin
    if (take) begin
      rdata <= line_mem[in_idx];
    end
    if (wr_en) begin
      line_mem[b_idx] <= sum;
    end
  end

  // Forward a write that lands on the same edge as the read of the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (take) begin
      byp_hit <= wr_en && (b_idx == in_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byp_sum <= sum;
      b_cmd   <= in_cmd;
      b_idx   <= in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (take) begin
      b_valid <= 1'b1;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end
  end

  // Accumulate the pixel into the block sum.
  always_comb begin
    if (!b_cmd.acc) begin
      base = '0;
    end else if (byp_hit) begin
      base = byp_sum;
    end else begin
      base = rdata;
    end
    sum.red   = base.red + SUM_W'(b_cmd.red);
    sum.green = base.green + SUM_W'(b_cmd.green);
    sum.blue  = base.blue + SUM_W'(b_cmd.blue);
  end

  // Average by shifting out twice the level.
  always_comb begin
    shamt     = {b_cmd.lv, 1'b0};
    res.red   = COLOR_W'(sum.red >> shamt);
    res.green = COLOR_W'(sum.green >> shamt);
    res.blue  = COLOR_W'(sum.blue >> shamt);
    res.last  = b_cmd.last;
  end

endmodule

`default_nettype wire

>>> rtl/mipmap_box_downsample_core.sv
// Mipmap box downsampler: 2^L x 2^L box average of a raster RGB stream.
// A texel passes through the command queue, back-end stage and result queue to the ports.
// Throughput: one pixel per cycle, one line store read-modify-write each, unless rq is full.
// Reset (synchronous, rst high): clears position, queues and registers to defaults;
// the line store is not cleared and needs no clearing pass.
`default_nettype none

`include "mipmap_box_downsample_core_assert.svh"

module mipmap_box_downsample_core #(
  parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_LEVEL  = mbd_pkg::DEF_MAX_LEVEL
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [mbd_pkg::COLOR_W-1:0]  in_red,
  input  logic [mbd_pkg::COLOR_W-1:0]  in_green,
  input  logic [mbd_pkg::COLOR_W-1:0]  in_blue,
  output logic                         empty,
  input  logic                         pop,
  output logic [mbd_pkg::COLOR_W-1:0]  out_red,
  output logic [mbd_pkg::COLOR_W-1:0]  out_green,
  output logic [mbd_pkg::COLOR_W-1:0]  out_blue,
  output logic                         last_texel,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbd_pkg::ADDR_W-1:0]   paddr,
  input  logic [mbd_pkg::DATA_W-1:0]   pwdata,
  output logic [mbd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import mbd_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CQ_W       = $bits(cmd_t) + IDX_W;

  logic [CFG_W-1:0]   base_width;
  logic [CFG_W-1:0]   base_height;
  logic [LEVEL_W-1:0] level;
  logic               wr_access;
  logic               cfg_wr;
  logic               accept;
  cmd_t               f_cmd;
  logic [IDX_W-1:0]   f_idx;
  logic               cq_full;
  logic               cq_empty;
  logic               cq_pop;
  logic [CQ_W-1:0]    cq_rdata;
  cmd_t               b_cmd;
  logic [IDX_W-1:0]   b_idx;
  logic               b_in_ready;
  logic               res_valid;
  logic               rq_full;
  logic               rq_push;
  res_t               res;
  res_t               rq_head;

  // Configuration port: write decode on the access phase.
  assign pready    = 1'b1;
  assign wr_access = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_BASE_WIDTH:  cfg_wr = wr_access;
      REG_BASE_HEIGHT: cfg_wr = wr_access;
      REG_LEVEL:       cfg_wr = wr_access;
      default:         cfg_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_width  <= RST_BASE_WIDTH;
      base_height <= RST_BASE_HEIGHT;
      level       <= RST_LEVEL;
    end else if (wr_access) begin
      case (paddr[3:2])
        REG_BASE_WIDTH:  base_width  <= pwdata[CFG_W-1:0];
        REG_BASE_HEIGHT: base_height <= pwdata[CFG_W-1:0];
        REG_LEVEL:       level       <= pwdata[LEVEL_W-1:0];
        default:         ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_BASE_WIDTH:  prdata = DATA_W'(base_width);
      REG_BASE_HEIGHT: prdata = DATA_W'(base_height);
      REG_LEVEL:       prdata = DATA_W'(level);
      default:         prdata = '0;
    endcase
  end

  // Front end classifies each pixel transaction.
  assign full   = cq_full;
  assign accept = push && !cq_full;

  mbd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_LEVEL  (MAX_LEVEL),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .red         (in_red),
    .green       (in_green),
    .blue        (in_blue),
    .base_width  (base_width),
    .base_height (base_height),
    .level       (level),
    .cfg_wr      (cfg_wr),
    .cmd         (f_cmd),
    .idx         (f_idx)
  );

  // Command queue between front and back ends.
  mbd_fifo #(
    .WIDTH (CQ_W)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata ({f_idx, f_cmd}),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  assign b_cmd = cq_rdata[$bits(cmd_t)-1:0];
  assign b_idx = cq_rdata[CQ_W-1:$bits(cmd_t)];

  // Back end accumulates block sums and averages finished blocks.
  assign cq_pop = !cq_empty && b_in_ready;

  mbd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LEVEL (MAX_LEVEL),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!cq_empty),
    .in_ready  (b_in_ready),
    .in_cmd    (b_cmd),
    .in_idx    (b_idx),
    .res_valid (res_valid),
    .res_ready (!rq_full),
    .res       (res)
  );

  // Result queue; its head drives the result ports.
  assign rq_push = res_valid && !rq_full;

  mbd_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (res),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_head),
    .empty (empty)
  );

  assign out_red    = rq_head.red;
  assign out_green  = rq_head.green;
  assign out_blue   = rq_head.blue;
  assign last_texel = rq_head.last;

  // Checks on the internal queue hand-offs.
  `MBD_ASSERT_NEVER(a_res_overflow, clk, rst, res_valid && rq_full && rq_push, "result queue pushed while full")
  `MBD_ASSERT_IMPLIES(a_cmd_pop_valid, clk, rst, cq_pop, !cq_empty && b_in_ready, "command queue popped while empty")
  `MBD_ASSERT_IMPLIES(a_front_stall, clk, rst, !cq_full && !rq_full, !full, "input stalled with room in both queues")

endmodule

`default_nettype wire
